// ----- src/line_break_tokenizer_macros.svh -----
// Assertion macros used by the tokenizer's result register (lbt_out).
`ifndef LINE_BREAK_TOKENIZER_MACROS_SVH
`define LINE_BREAK_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define LBT_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("line_break_tokenizer: assertion failed");
`define LBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_break_tokenizer: assertion failed");
`else
`define LBT_ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define LBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/lbt_pkg.sv -----
// Types, constants and helper functions of the line-break tokenizer.
package lbt_pkg;

    localparam int POSITION_BITS       = 16;
    localparam int WIDTH_FRACTION_BITS = 8;
    localparam int TOKEN_WIDTH_BITS    = 16 + WIDTH_FRACTION_BITS;
    localparam int LENGTH_BITS         = 16;
    localparam int START_BITS          = 16;
    localparam int CHAR_BITS           = 16;

    typedef logic [POSITION_BITS-1:0]    t_pos;
    typedef logic [LENGTH_BITS-1:0]      t_len;
    typedef logic [START_BITS-1:0]       t_start;
    typedef logic [TOKEN_WIDTH_BITS-1:0] t_twidth;
    typedef logic [TOKEN_WIDTH_BITS:0]   t_wsum;
    typedef logic [CHAR_BITS-1:0]        t_char;

    localparam t_len    LENGTH_MAX      = '1;
    localparam t_twidth TOKEN_WIDTH_MAX = '1;

    localparam t_char CH_NEWLINE = 16'h000A;
    localparam t_char CH_SPACE   = 16'h0020;
    localparam t_char CH_HYPHEN  = 16'h002D;
    localparam t_char CH_SLASH   = 16'h002F;
    localparam t_char CH_EN_DASH = 16'h2013;
    localparam t_char CH_EM_DASH = 16'h2014;

    typedef enum logic [1:0] {
        KIND_NEWLINE = 2'd0,
        KIND_SPACE   = 2'd1,
        KIND_ATOM    = 2'd2,
        KIND_HYPHENS = 2'd3
    } t_token_kind;

    // LEAD is a leading hyphen group that has not yet met its first atom.
    typedef enum logic [2:0] {
        OPEN_NONE  = 3'd0,
        OPEN_SPACE = 3'd1,
        OPEN_LEAD  = 3'd2,
        OPEN_ATOM  = 3'd3,
        OPEN_HYPH  = 3'd4
    } t_open_kind;

    typedef struct packed {
        t_char char_code;
        t_char char_width;
        logic  end_of_text;
    } t_in_beat;

    typedef struct packed {
        t_token_kind token_kind;
        t_start      token_start;
        t_len        token_length;
        t_twidth     token_width;
        logic        run_last;
        logic        text_done;
    } t_out_beat;

    typedef struct packed {
        t_open_kind kind;
        t_pos       start;
        t_len       length;
        t_twidth    width;
    } t_open_state;

    typedef struct packed {
        logic [1:0] count;
        t_out_beat  tok0;
        t_out_beat  tok1;
    } t_token_pair;

    function automatic logic is_hyphen_slash(input t_char c);
        return (c == CH_HYPHEN) || (c == CH_SLASH) || (c == CH_EN_DASH) ||
               (c == CH_EM_DASH);
    endfunction

    function automatic t_token_kind open_to_token(input t_open_kind k);
        t_token_kind r;
        case (k)
            OPEN_SPACE: r = KIND_SPACE;
            OPEN_HYPH:  r = KIND_HYPHENS;
            default:    r = KIND_ATOM;
        endcase
        return r;
    endfunction

endpackage

// ----- src/line_break_tokenizer.sv -----
// An accepted character is held in the input register, then its tokens go to the
// result register. Throughput: one character per cycle while the output is ready;
// two tokens from one character hold the result register, leaving one per cycle.
// Synchronous active-low reset empties the input and result registers and clears
// the open token and the character position; the block is ready right after reset.
module line_break_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lbt_pkg::t_in_beat  i_in_data,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output lbt_pkg::t_out_beat o_out_data,
    input  logic               i_out_ready
);

    logic                 r_in_valid;
    lbt_pkg::t_in_beat    r_in;
    lbt_pkg::t_open_state r_state;
    lbt_pkg::t_open_state n_state;
    lbt_pkg::t_pos        r_pos;
    lbt_pkg::t_pos        n_pos;
    lbt_pkg::t_token_pair pair;
    logic                 load_ready;
    logic                 advance;

    assign advance    = r_in_valid && load_ready;
    assign o_in_ready = !r_in_valid || load_ready;

    lbt_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .i_pos   (r_pos),
        .o_state (n_state),
        .o_pos   (n_pos),
        .o_pair  (pair)
    );

    lbt_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_pair       (pair),
        .o_load_ready (load_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_pos      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

endmodule

// ----- src/lbt_step.sv -----
// Per-character tokenizer step: classifies the character, updates the open token
// and forms up to two finished tokens.
module lbt_step (
    input  lbt_pkg::t_in_beat    i_item,
    input  lbt_pkg::t_open_state i_state,
    input  lbt_pkg::t_pos        i_pos,
    output lbt_pkg::t_open_state o_state,
    output lbt_pkg::t_pos        o_pos,
    output lbt_pkg::t_token_pair o_pair
);

    always_comb begin
        logic                 is_nl;
        logic                 is_sp;
        logic                 is_hy;
        logic                 has_open;
        logic                 flush_prev;
        logic                 extend;
        logic                 has_b;
        lbt_pkg::t_wsum       w_sum;
        lbt_pkg::t_open_state nxt;
        lbt_pkg::t_out_beat   tok_a;
        lbt_pkg::t_out_beat   tok_b;

        is_nl    = (i_item.char_code == lbt_pkg::CH_NEWLINE);
        is_sp    = (i_item.char_code == lbt_pkg::CH_SPACE);
        is_hy    = lbt_pkg::is_hyphen_slash(i_item.char_code);
        has_open = (i_state.kind != lbt_pkg::OPEN_NONE);

        if (is_nl) begin
            flush_prev = has_open;
            extend     = 1'b0;
        end else if (is_sp) begin
            extend     = (i_state.kind == lbt_pkg::OPEN_SPACE);
            flush_prev = has_open && !extend;
        end else if (is_hy) begin
            extend     = (i_state.kind == lbt_pkg::OPEN_LEAD) ||
                         (i_state.kind == lbt_pkg::OPEN_HYPH);
            flush_prev = has_open && !extend;
        end else begin
            extend     = (i_state.kind == lbt_pkg::OPEN_ATOM) ||
                         (i_state.kind == lbt_pkg::OPEN_LEAD);
            flush_prev = has_open && !extend;
        end

        // Saturating growth of the open token.
        w_sum = {1'b0, i_state.width} + lbt_pkg::t_wsum'(i_item.char_width);

        if (extend) begin
            nxt.start  = i_state.start;
            nxt.length = (i_state.length == lbt_pkg::LENGTH_MAX) ?
                         i_state.length : i_state.length + lbt_pkg::t_len'(1);
            nxt.width  = w_sum[lbt_pkg::TOKEN_WIDTH_BITS] ?
                         lbt_pkg::TOKEN_WIDTH_MAX :
                         w_sum[lbt_pkg::TOKEN_WIDTH_BITS-1:0];
        end else begin
            nxt.start  = i_pos;
            nxt.length = lbt_pkg::t_len'(1);
            nxt.width  = lbt_pkg::t_twidth'(i_item.char_width);
        end

        if (is_nl) begin
            nxt.kind = lbt_pkg::OPEN_NONE;
        end else if (is_sp) begin
            nxt.kind = lbt_pkg::OPEN_SPACE;
        end else if (is_hy) begin
            if (extend) begin
                nxt.kind = i_state.kind;
            end else if (i_state.kind == lbt_pkg::OPEN_ATOM) begin
                nxt.kind = lbt_pkg::OPEN_HYPH;
            end else begin
                nxt.kind = lbt_pkg::OPEN_LEAD;
            end
        end else begin
            nxt.kind = lbt_pkg::OPEN_ATOM;
        end

        tok_a.token_kind   = lbt_pkg::open_to_token(i_state.kind);
        tok_a.token_start  = lbt_pkg::t_start'(i_state.start);
        tok_a.token_length = i_state.length;
        tok_a.token_width  = i_state.width;
        tok_a.run_last     = 1'b0;
        tok_a.text_done    = 1'b0;

        // The second token is the newline itself, or the open token flushed at text end.
        if (is_nl) begin
            tok_b.token_kind   = lbt_pkg::KIND_NEWLINE;
            tok_b.token_start  = lbt_pkg::t_start'(i_pos);
            tok_b.token_length = lbt_pkg::t_len'(1);
            tok_b.token_width  = '0;
        end else begin
            tok_b.token_kind   = lbt_pkg::open_to_token(nxt.kind);
            tok_b.token_start  = lbt_pkg::t_start'(nxt.start);
            tok_b.token_length = nxt.length;
            tok_b.token_width  = nxt.width;
        end
        tok_b.run_last  = 1'b1;
        tok_b.text_done = i_item.end_of_text;
        has_b           = is_nl || i_item.end_of_text;

        if (flush_prev && !has_b) begin
            tok_a.run_last = 1'b1;
        end

        o_pair.count = {1'b0, flush_prev} + {1'b0, has_b};
        o_pair.tok0  = flush_prev ? tok_a : tok_b;
        o_pair.tok1  = tok_b;

        if (i_item.end_of_text) begin
            o_state = '0;
            o_pos   = '0;
        end else begin
            o_state = nxt;
            o_pos   = i_pos + lbt_pkg::t_pos'(1);
        end
    end

endmodule

// ----- src/lbt_out.sv -----
// Result register of up to two tokens, sent one per cycle while i_out_ready.
`include "line_break_tokenizer_macros.svh"

module lbt_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load_valid,
    input  lbt_pkg::t_token_pair i_pair,
    output logic                 o_load_ready,
    output logic                 o_out_valid,
    output lbt_pkg::t_out_beat   o_out_data,
    input  logic                 i_out_ready
);

    logic [1:0]         r_count;
    logic [1:0]         n_count;
    lbt_pkg::t_out_beat r_tok0;
    lbt_pkg::t_out_beat n_tok0;
    lbt_pkg::t_out_beat r_tok1;
    logic               pop;
    logic               load;

    assign o_out_valid  = (r_count != 2'd0);
    assign o_out_data   = r_tok0;
    assign pop          = o_out_valid && i_out_ready;
    // A pair enters if empty or if the last held token leaves in this cycle.
    assign o_load_ready = (r_count == 2'd0) || ((r_count == 2'd1) && i_out_ready);
    assign load         = i_load_valid && o_load_ready;

    always_comb begin
        n_count = r_count;
        n_tok0  = r_tok0;
        if (load) begin
            n_count = i_pair.count;
            n_tok0  = i_pair.tok0;
        end else if (pop) begin
            n_count = r_count - 2'd1;
            n_tok0  = r_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok0 <= n_tok0;
        if (load) begin
            r_tok1 <= i_pair.tok1;
        end
    end

    `LBT_ASSERT_HOLDS(a_count_range, i_clk, i_rst_n, r_count != 2'd3)
    `LBT_ASSERT_HOLDS(a_single_is_last, i_clk, i_rst_n, (r_count != 2'd1) || r_tok0.run_last)
    `LBT_ASSERT_HOLDS(a_pair_first_not_last, i_clk, i_rst_n, (r_count != 2'd2) || !r_tok0.run_last)
    `LBT_ASSERT_NEXT(a_pair_second_follows, i_clk, i_rst_n, pop && (r_count == 2'd2), o_out_valid && o_out_data.run_last)

endmodule

// ----- dv/tb_line_break_tokenizer.sv -----
// Self-checking testbench of the line-break tokenizer: directed, saturating and random texts.
`timescale 1ns / 1ps

module tb_line_break_tokenizer;

    localparam int PACE_STEADY = 0;
    localparam int PACE_LIGHT  = 1;
    localparam int PACE_HEAVY  = 2;

    localparam int            RANDOM_CHARS  = 980;
    localparam int            HOLD_AT_TOKEN = 200;
    localparam int            HOLD_CYCLES   = 400;
    localparam lbt_pkg::t_char CH_LETTER_A  = 16'h0061;
    localparam lbt_pkg::t_char CH_LETTER_X  = 16'h0078;
    localparam lbt_pkg::t_char WIDTH_MAX    = 16'hFFFF;

    typedef struct {
        lbt_pkg::t_in_beat beat;
        int                gap;
    } t_char_job;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               send_valid = 1'b0;
    lbt_pkg::t_in_beat  send_beat  = '0;
    logic               in_ready;
    logic               tok_valid;
    lbt_pkg::t_out_beat tok_beat;
    logic               tok_ready  = 1'b0;

    t_char_job          chars_to_send[$];
    t_char_job          next_job;
    lbt_pkg::t_out_beat tokens_due[$];
    int                 chars_total;
    int                 chars_taken  = 0;
    int                 send_wait    = 0;
    int                 tokens_seen  = 0;
    int                 ready_wait   = 0;
    int                 hold_left    = 0;
    logic               hold_done    = 1'b0;
    int                 errors       = 0;

    // Predicted tokenizer state.
    lbt_pkg::t_open_kind run_kind  = lbt_pkg::OPEN_NONE;
    lbt_pkg::t_pos       run_start = '0;
    lbt_pkg::t_len       run_len   = '0;
    lbt_pkg::t_twidth    run_width = '0;
    lbt_pkg::t_pos       next_pos  = '0;
    lbt_pkg::t_out_beat  step_toks[2];
    int                  step_n;

    line_break_tokenizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (send_valid),
        .i_in_data   (send_beat),
        .o_in_ready  (in_ready),
        .o_out_valid (tok_valid),
        .o_out_data  (tok_beat),
        .i_out_ready (tok_ready)
    );

    always #2 i_clk = ~i_clk;

    function automatic void add_token(lbt_pkg::t_token_kind k, lbt_pkg::t_start s,
                                      lbt_pkg::t_len l, lbt_pkg::t_twidth w);
        lbt_pkg::t_out_beat t;
        t = '0;
        t.token_kind   = k;
        t.token_start  = s;
        t.token_length = l;
        t.token_width  = w;
        step_toks[step_n] = t;
        step_n++;
    endfunction

    function automatic void close_run();
        case (run_kind)
            lbt_pkg::OPEN_SPACE:
                add_token(lbt_pkg::KIND_SPACE, run_start, run_len, run_width);
            lbt_pkg::OPEN_LEAD, lbt_pkg::OPEN_ATOM:
                add_token(lbt_pkg::KIND_ATOM, run_start, run_len, run_width);
            lbt_pkg::OPEN_HYPH:
                add_token(lbt_pkg::KIND_HYPHENS, run_start, run_len, run_width);
            default: ;
        endcase
        run_kind = lbt_pkg::OPEN_NONE;
    endfunction

    function automatic void open_run(lbt_pkg::t_open_kind k, lbt_pkg::t_char w);
        run_kind  = k;
        run_start = next_pos;
        run_len   = lbt_pkg::t_len'(1);
        run_width = lbt_pkg::t_twidth'(w);
    endfunction

    function automatic void grow_run(lbt_pkg::t_char w);
        lbt_pkg::t_wsum sum;
        if (run_len != lbt_pkg::LENGTH_MAX) begin
            run_len++;
        end
        sum = {1'b0, run_width} + lbt_pkg::t_wsum'(w);
        run_width = sum[lbt_pkg::TOKEN_WIDTH_BITS] ? lbt_pkg::TOKEN_WIDTH_MAX :
                    sum[lbt_pkg::TOKEN_WIDTH_BITS-1:0];
    endfunction

    // Works out the tokens that one accepted character releases.
    function automatic void predict_tokens(lbt_pkg::t_in_beat b);
        logic dash;
        dash = (b.char_code == lbt_pkg::CH_HYPHEN) || (b.char_code == lbt_pkg::CH_SLASH) ||
               (b.char_code == lbt_pkg::CH_EN_DASH) || (b.char_code == lbt_pkg::CH_EM_DASH);
        step_n = 0;
        if (b.char_code == lbt_pkg::CH_NEWLINE) begin
            close_run();
            add_token(lbt_pkg::KIND_NEWLINE, next_pos, lbt_pkg::t_len'(1), '0);
        end else if (b.char_code == lbt_pkg::CH_SPACE) begin
            if (run_kind == lbt_pkg::OPEN_SPACE) begin
                grow_run(b.char_width);
            end else begin
                close_run();
                open_run(lbt_pkg::OPEN_SPACE, b.char_width);
            end
        end else if (dash) begin
            if (run_kind == lbt_pkg::OPEN_LEAD || run_kind == lbt_pkg::OPEN_HYPH) begin
                grow_run(b.char_width);
            end else if (run_kind == lbt_pkg::OPEN_ATOM) begin
                close_run();
                open_run(lbt_pkg::OPEN_HYPH, b.char_width);
            end else begin
                close_run();
                open_run(lbt_pkg::OPEN_LEAD, b.char_width);
            end
        end else begin
            if (run_kind == lbt_pkg::OPEN_ATOM) begin
                grow_run(b.char_width);
            end else if (run_kind == lbt_pkg::OPEN_LEAD) begin
                // The leading dash group becomes part of the word's first atom.
                grow_run(b.char_width);
                run_kind = lbt_pkg::OPEN_ATOM;
            end else begin
                close_run();
                open_run(lbt_pkg::OPEN_ATOM, b.char_width);
            end
        end
        next_pos = next_pos + 1'b1;
        if (b.end_of_text) begin
            close_run();
            if (step_n > 0) begin
                step_toks[step_n-1].text_done = 1'b1;
            end
            run_start = '0;
            run_len   = '0;
            run_width = '0;
            next_pos  = '0;
        end
        if (step_n > 0) begin
            step_toks[step_n-1].run_last = 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            tokens_due.push_back(step_toks[i]);
        end
    endfunction

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_token(lbt_pkg::t_out_beat got);
        lbt_pkg::t_out_beat want;
        if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t ns: token with none pending, expected nothing, actual %h",
                     $time, got);
        end else begin
            want = tokens_due.pop_front();
            compare_field("token_kind", want.token_kind, got.token_kind);
            compare_field("token_start", want.token_start, got.token_start);
            compare_field("token_length", want.token_length, got.token_length);
            compare_field("token_width", want.token_width, got.token_width);
            compare_field("run_last", want.run_last, got.run_last);
            compare_field("text_done", want.text_done, got.text_done);
        end
    endtask

    function automatic int pause_for(int pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_LIGHT:  return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 14)) : 0;
            default:     return int'($urandom_range(0, 14));
        endcase
    endfunction

    // Sender: each character waits out its own gap before valid goes up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            send_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (send_valid && in_ready) begin
                predict_tokens(send_beat);
                chars_taken++;
            end
            if (send_valid && !in_ready) begin
                // Beat still pending: hold valid and payload.
            end else if (chars_to_send.size() > 0 && send_wait < chars_to_send[0].gap) begin
                send_wait++;
                send_valid <= 1'b0;
            end else if (chars_to_send.size() > 0) begin
                next_job = chars_to_send.pop_front();
                send_beat  <= next_job.beat;
                send_valid <= 1'b1;
                send_wait = 0;
            end else begin
                send_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every token beat and pauses ready on its own schedule.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tok_ready <= 1'b0;
            ready_wait = 0;
        end else begin
            if (tok_valid && tok_ready) begin
                check_token(tok_beat);
                tokens_seen++;
                ready_wait = pause_for((tokens_seen / 97) % 3);
            end else if (ready_wait > 0) begin
                ready_wait--;
            end
            // One long hold-off lets the block fill up and stall its input.
            if (!hold_done && tokens_seen >= HOLD_AT_TOKEN) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            tok_ready <= (ready_wait == 0) && (hold_left == 0);
        end
    end

    task automatic queue_char(lbt_pkg::t_char code, lbt_pkg::t_char w, logic eot, int gap);
        t_char_job job;
        job.beat.char_code   = code;
        job.beat.char_width  = w;
        job.beat.end_of_text = eot;
        job.gap = gap;
        chars_to_send.push_back(job);
    endtask

    function automatic lbt_pkg::t_char pick_char();
        case ($urandom_range(0, 9))
            0, 1: return lbt_pkg::CH_SPACE;
            2:    return lbt_pkg::CH_NEWLINE;
            3, 4: begin
                case ($urandom_range(0, 3))
                    0:       return lbt_pkg::CH_HYPHEN;
                    1:       return lbt_pkg::CH_SLASH;
                    2:       return lbt_pkg::CH_EN_DASH;
                    default: return lbt_pkg::CH_EM_DASH;
                endcase
            end
            default: begin
                if ($urandom_range(0, 4) == 0) begin
                    return lbt_pkg::t_char'($urandom());
                end
                return CH_LETTER_A + lbt_pkg::t_char'($urandom_range(0, 25));
            end
        endcase
    endfunction

    function automatic lbt_pkg::t_char pick_width();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WIDTH_MAX;
            default: return lbt_pkg::t_char'($urandom());
        endcase
    endfunction

    initial begin
        int pace;
        int len;
        int sent;
        logic eot;

        // Leading dashes join the first atom; later dash runs stand alone.
        queue_char(lbt_pkg::CH_HYPHEN, WIDTH_MAX, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_HYPHEN, 16'h0000, 1'b0, pause_for(PACE_LIGHT));
        queue_char(CH_LETTER_A, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_EN_DASH, 16'h0280, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_EM_DASH, 16'h0300, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_SLASH, 16'h0080, 1'b0, pause_for(PACE_LIGHT));
        queue_char(CH_LETTER_A, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_SPACE, 16'h0200, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_SPACE, WIDTH_MAX, 1'b0, pause_for(PACE_LIGHT));
        // A newline closes the space run and carries width zero.
        queue_char(lbt_pkg::CH_NEWLINE, 16'h0400, 1'b0, pause_for(PACE_LIGHT));
        // A word of dashes only is one atom.
        queue_char(lbt_pkg::CH_SLASH, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_SPACE, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        queue_char(CH_LETTER_X, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        // A dash run that ends the word is a token of its own.
        queue_char(lbt_pkg::CH_HYPHEN, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_NEWLINE, WIDTH_MAX, 1'b0, pause_for(PACE_LIGHT));
        queue_char(16'hFFFF, WIDTH_MAX, 1'b0, pause_for(PACE_LIGHT));
        queue_char(16'h0000, 16'h0000, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_HYPHEN, 16'h5555, 1'b1, pause_for(PACE_LIGHT));
        // The end of text on a newline, and one-character texts of each kind.
        queue_char(lbt_pkg::CH_NEWLINE, 16'hAAAA, 1'b1, pause_for(PACE_LIGHT));
        queue_char(CH_LETTER_X, 16'h0100, 1'b1, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_SPACE, 16'h0100, 1'b1, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_EM_DASH, 16'h0100, 1'b1, pause_for(PACE_LIGHT));
        queue_char(CH_LETTER_A, 16'h0100, 1'b0, pause_for(PACE_LIGHT));
        queue_char(lbt_pkg::CH_NEWLINE, 16'h0100, 1'b1, pause_for(PACE_LIGHT));

        // A wide space run saturates its width.
        for (int i = 0; i < 300; i++) begin
            queue_char(lbt_pkg::CH_SPACE, WIDTH_MAX, i == 299, 0);
        end

        // Random texts, each with its own pace; a few end early.
        sent = 0;
        while (sent < RANDOM_CHARS) begin
            pace = $urandom_range(PACE_STEADY, PACE_HEAVY);
            len  = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                eot = (i == len - 1) || ($urandom_range(0, 24) == 0);
                queue_char(pick_char(), pick_width(), eot, pause_for(pace));
            end
            sent += len;
        end
        chars_total = chars_to_send.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_taken < chars_total || tokens_due.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- line_break_tokenizer.f -----
+incdir+src
src/lbt_pkg.sv
src/lbt_step.sv
src/lbt_out.sv
src/line_break_tokenizer.sv
dv/tb_line_break_tokenizer.sv
